// File: rtl/rsn_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rsn_pkg
// shared constants and types for the rootsift row normalizer
// ----------------------------------------------------------------------------
package rsn_pkg;
    localparam int ROW_LENGTH_DEFAULT = 128;
    localparam int SUM_W   = 15;
    localparam int ELEM_W  = 8;
    localparam int ROOT_W  = 16;
    localparam int QUO_W   = 33;

    typedef enum logic [2:0] {
        ST_LOAD,
        ST_READ,
        ST_CALC,
        ST_OUT
    } rsn_state_t;

    // sequencing of the root unit
    typedef enum logic [1:0] {
        R_IDLE,
        R_DIV,
        R_SQRT
    } rsn_root_phase_t;

    // request into the root unit
    typedef struct packed {
        logic               start;
        logic [ELEM_W-1:0]  elem;
        logic [SUM_W-1:0]   sum;
    } rsn_root_req_t;

    // status back from the root unit
    typedef struct packed {
        logic               busy;
        logic               done;
        logic [ROOT_W-1:0]  root;
    } rsn_root_rsp_t;
endpackage
`default_nettype wire

// File: rtl/rsn_root_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rsn_root_unit
// floor(65536*sqrt(x/sum)): restoring divide then digit-by-digit square root
// ----------------------------------------------------------------------------
module rsn_root_unit
    import rsn_pkg::*;
(
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire rsn_root_req_t req,
    output rsn_root_rsp_t      rsp
);
    rsn_root_phase_t    phase_reg, phase_next;
    logic [5:0]         cnt_reg;
    logic [SUM_W-1:0]   div_reg;
    logic [SUM_W:0]     rem_reg;
    logic [40:0]        num_reg;      // shifting dividend x<<32
    logic [QUO_W-1:0]   quo_reg;
    logic [QUO_W:0]     sv_reg;       // sqrt remainder value
    logic [QUO_W:0]     res_reg;
    logic [QUO_W:0]     bit_reg;
    logic               done_reg;
    logic               zero_reg;

    logic [SUM_W:0]     rem_sh;
    logic [QUO_W:0]     trial;

    assign rem_sh = {rem_reg[SUM_W-1:0], num_reg[40]};
    assign trial  = res_reg + bit_reg;

    // next phase
    always_comb begin
        phase_next = phase_reg;
        unique case (phase_reg)
            R_IDLE:  if (req.start) phase_next = R_DIV;
            R_DIV:   if (cnt_reg == 6'd1) phase_next = R_SQRT;
            R_SQRT:  if (cnt_reg == 6'd0) phase_next = R_IDLE;
            default: phase_next = R_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= R_IDLE;
            done_reg  <= 1'b0;
        end else begin
            phase_reg <= phase_next;
            done_reg  <= (phase_reg == R_SQRT) && (cnt_reg == 6'd0);
        end
    end

    // datapath
    always_ff @(posedge aclk) begin
        unique case (phase_reg)
            R_IDLE: begin
                if (req.start) begin
                    div_reg   <= req.sum;
                    zero_reg  <= (req.sum == '0);
                    num_reg   <= {1'b0, req.elem, 32'd0};
                    rem_reg   <= '0;
                    quo_reg   <= '0;
                    cnt_reg   <= 6'd41;
                end
            end
            R_DIV: begin
                num_reg <= {num_reg[39:0], 1'b0};
                if (rem_sh >= {1'b0, div_reg}) begin
                    rem_reg <= rem_sh - {1'b0, div_reg};
                    quo_reg <= {quo_reg[QUO_W-2:0], 1'b1};
                end else begin
                    rem_reg <= rem_sh;
                    quo_reg <= {quo_reg[QUO_W-2:0], 1'b0};
                end
                if (cnt_reg == 6'd1) begin
                    bit_reg   <= {2'b01, 32'd0};
                    res_reg   <= '0;
                    cnt_reg   <= 6'd17;
                end else begin
                    cnt_reg <= cnt_reg - 6'd1;
                end
            end
            R_SQRT: begin
                if (cnt_reg == 6'd17) begin
                    sv_reg <= {1'b0, quo_reg};
                end else begin
                    if (sv_reg >= trial) begin
                        sv_reg  <= sv_reg - trial;
                        res_reg <= (res_reg >> 1) + bit_reg;
                    end else begin
                        res_reg <= res_reg >> 1;
                    end
                    bit_reg <= bit_reg >> 2;
                end
                cnt_reg <= cnt_reg - 6'd1;
            end
            default: ;
        endcase
    end

    // outputs
    always_comb begin
        rsp.busy = (phase_reg != R_IDLE);
        rsp.done = done_reg;
        if (zero_reg) rsp.root = '0;
        else if (res_reg > 34'd65535) rsp.root = 16'hFFFF;
        else rsp.root = res_reg[ROOT_W-1:0];
    end
endmodule
`default_nettype wire

// File: rtl/rootsift_row_normalizer_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rootsift_row_normalizer_unit
// rootsift row normalizer: stores a row, then emits sqrt(x/sum) pairs
// ----------------------------------------------------------------------------
// channel | dir | tdata                         | tuser / tlast
// s_      | in  | [7:0] element_value           | tlast last_element
// m_      | out | [15:0] root_even [31:16] odd  | tuser[0] odd_valid,
//         |     |                               | tuser[1] row_overflow, tlast last_pair
// loading takes one word per cycle into the row memory while the unit is in its load state
// after the last word each element passes in turn through the shared root unit
//   (memory read, start, 41 divide steps, square-root steps, done handoff)
// each result word then waits on the output until m_tready accepts it
// reset clears counters and state only; the row memory needs no clearing
// no input is taken while a row is being emitted; m_tready stalls hold state
// ----------------------------------------------------------------------------
module rootsift_row_normalizer_unit
    import rsn_pkg::*;
#(
    parameter int ROW_LENGTH = ROW_LENGTH_DEFAULT
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // [7:0] element_value
    input  wire logic        s_tlast,   // last_element
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [31:0]      m_tdata,   // [15:0] root_even, [31:16] root_odd
    output logic [1:0]       m_tuser,   // [0] odd_valid, [1] row_overflow
    output logic             m_tlast    // last_pair
);
    localparam int AW = (ROW_LENGTH > 1) ? $clog2(ROW_LENGTH) : 1;
    localparam int CW = $clog2(ROW_LENGTH + 1);

    // row memory
    logic [ELEM_W-1:0] mem [ROW_LENGTH];
    logic [ELEM_W-1:0] rd_data_reg;

    rsn_state_t        state_reg, state_next;
    logic [SUM_W-1:0]  sum_reg;
    logic [CW-1:0]     count_reg;
    logic              ovf_reg;
    logic [CW-1:0]     idx_reg;      // element being processed
    logic [ROOT_W-1:0] even_reg;
    logic              have_even_reg;
    logic              start_reg;

    rsn_root_req_t     req;
    rsn_root_rsp_t     rsp;

    logic in_fire, out_fire, full, row_end;
    assign full     = (count_reg == CW'(ROW_LENGTH));
    assign in_fire  = s_tvalid && s_tready;
    assign out_fire = m_tvalid && m_tready;
    assign row_end  = (idx_reg + CW'(1) >= count_reg);

    always_ff @(posedge aclk) begin
        if (in_fire && !full) mem[count_reg[AW-1:0]] <= s_tdata;
        rd_data_reg <= mem[idx_reg[AW-1:0]];
    end

    rsn_root_unit u_root (.aclk(aclk), .aresetn(aresetn), .req(req), .rsp(rsp));

    assign req.start = start_reg;
    assign req.elem  = rd_data_reg;
    assign req.sum   = sum_reg;

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_LOAD: if (in_fire && s_tlast) state_next = ST_READ;
            ST_READ: state_next = ST_CALC;
            ST_CALC: begin
                if (rsp.done) begin
                    if (!have_even_reg && !row_end) state_next = ST_READ;
                    else state_next = ST_OUT;
                end
            end
            ST_OUT: begin
                if (m_tready) state_next = m_tlast ? ST_LOAD : ST_READ;
            end
            default: state_next = ST_LOAD;
        endcase
    end

    // outputs
    always_comb begin
        s_tready = (state_reg == ST_LOAD);
        m_tvalid = (state_reg == ST_OUT);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_LOAD;
            sum_reg       <= '0;
            count_reg     <= '0;
            ovf_reg       <= 1'b0;
            idx_reg       <= '0;
            have_even_reg <= 1'b0;
            start_reg     <= 1'b0;
        end else begin
            state_reg <= state_next;
            start_reg <= (state_reg == ST_READ);
            if (in_fire) begin
                if (!full) begin
                    sum_reg   <= sum_reg + SUM_W'(s_tdata);
                    count_reg <= count_reg + CW'(1);
                end else begin
                    ovf_reg <= 1'b1;
                end
            end
            if (state_reg == ST_CALC && rsp.done) begin
                idx_reg <= idx_reg + CW'(1);
                if (!have_even_reg) begin
                    even_reg      <= rsp.root;
                    have_even_reg <= 1'b1;
                    m_tdata       <= {16'd0, rsp.root};
                    m_tuser       <= {ovf_reg, 1'b0};
                    m_tlast       <= row_end;
                end else begin
                    m_tdata       <= {rsp.root, even_reg};
                    m_tuser       <= {ovf_reg, 1'b1};
                    m_tlast       <= row_end;
                end
            end
            if (out_fire) begin
                have_even_reg <= 1'b0;
                if (m_tlast) begin
                    sum_reg   <= '0;
                    count_reg <= '0;
                    ovf_reg   <= 1'b0;
                    idx_reg   <= '0;
                end
            end
        end
    end

    // no input taken while results are pending
    a_no_in_while_out: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !s_tready) else $error("input accepted during output");
    // fill count never exceeds the row store
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CW'(ROW_LENGTH)) else $error("count overflow");
    // the root unit is only started when idle
    a_start_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        start_reg |-> !rsp.busy) else $error("root unit restarted while busy");
endmodule
`default_nettype wire

// File: bench/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// drives descriptor rows into the rootsift row normalizer and checks every
// emitted root pair against a local integer predictor, with random gaps on
// both channels, one long output stall and one drain pause
// ----------------------------------------------------------------------------
module testbench;
    import rsn_pkg::*;

    localparam int ROWS = 128;
    localparam int CYCLE_LIMIT = 3000000;

    typedef struct packed {
        logic [15:0] root_even;
        logic [15:0] root_odd;
        logic        odd_valid;
        logic        row_overflow;
        logic        last_pair;
    } pair_t;

    typedef struct {
        logic [7:0] value;
        logic       last;
        logic       has_pair;   // a typed-in first pair is checked
        pair_t      pair;
    } step_t;

    logic        aclk = 0;
    logic        aresetn = 0;
    logic        s_tvalid = 0;
    logic        s_tready;
    logic [7:0]  s_tdata = '0;
    logic        s_tlast = 0;
    logic        m_tvalid;
    logic        m_tready = 0;
    logic [31:0] m_tdata;
    logic [1:0]  m_tuser;
    logic        m_tlast;

    rootsift_row_normalizer_unit dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .m_tuser(m_tuser), .m_tlast(m_tlast)
    );

    always begin
        #1 aclk = 1;
        #1 aclk = 0;
    end

    // predictor state
    logic [7:0]  row_buf [ROWS];
    logic [14:0] run_sum = '0;
    int          run_count = 0;
    logic        run_over = 0;
    pair_t       pending_pairs [$];
    // one entry per directed row, in row order
    pair_t       typed_pairs [$];
    bit          typed_has [$];
    bit          row_start = 1;

    int errors = 0;
    int words_in = 0;
    int pairs_out = 0;
    int rows_done = 0;
    int cycles = 0;
    bit hold_off = 0;
    bit stim_done = 0;

    function automatic logic [15:0] root_of(input logic [7:0] x, input logic [14:0] s);
        logic [63:0] q;
        logic [32:0] r;
        logic [32:0] b;
        if (s == '0) return 16'd0;
        q = ({56'd0, x} << 32) / {49'd0, s};
        r = '0;
        for (int k = 16; k >= 0; k--) begin
            b = r | (33'd1 << k);
            if ({31'd0, b} * {31'd0, b} <= q) r = b;
        end
        return (r > 33'd65535) ? 16'hffff : r[15:0];
    endfunction

    task automatic predict_word(input logic [7:0] v, input logic l);
        pair_t p;
        int n;
        if (run_count < ROWS) begin
            row_buf[run_count] = v;
            run_sum = run_sum + {7'd0, v};
            run_count++;
        end else begin
            run_over = 1;
        end
        if (!l) return;
        n = (run_count + 1) / 2;
        for (int k = 0; k < n; k++) begin
            p.root_even = root_of(row_buf[2*k], run_sum);
            p.odd_valid = (2*k + 1 < run_count);
            p.root_odd = p.odd_valid ? root_of(row_buf[2*k+1], run_sum) : 16'd0;
            p.row_overflow = run_over;
            p.last_pair = (k + 1 == n);
            pending_pairs.push_back(p);
        end
        run_sum = '0;
        run_count = 0;
        run_over = 0;
    endtask

    // send one word, holding valid until accepted
    task automatic send_word(input logic [7:0] v, input logic l);
        s_tvalid <= 1;
        s_tdata <= v;
        s_tlast <= l;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        predict_word(v, l);
        words_in++;
    endtask

    task automatic idle_gap();
        int g;
        g = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 40) : $urandom_range(0, 2);
        if (g > 0) begin
            s_tvalid <= 0;
            repeat (g) @(posedge aclk);
        end
    endtask

    task automatic wait_drained();
        s_tvalid <= 0;
        @(posedge aclk);
        while (pending_pairs.size() != 0) @(posedge aclk);
    endtask

    // random row: mostly short, a few full length or overflowing
    task automatic random_row();
        int len;
        int mode;
        int sel;
        mode = $urandom_range(0, 19);
        if (mode == 0) len = ROWS + $urandom_range(1, 4);
        else if (mode == 1) len = ROWS;
        else len = $urandom_range(1, 12);
        sel = $urandom_range(0, 3);
        for (int i = 0; i < len; i++) begin
            logic [7:0] v;
            case (sel)
                0: v = 8'($urandom_range(0, 255));
                1: v = ($urandom_range(0, 3) == 0) ? 8'd0 : 8'($urandom_range(0, 255));
                2: v = 8'($urandom_range(0, 3));
                default: v = ($urandom_range(0, 1) != 0) ? 8'hff : 8'h00;
            endcase
            send_word(v, i == len - 1);
            idle_gap();
        end
    endtask

    // directed table
    step_t table_rows [] = '{
        // single zero word: zero sum gives zero root, padded odd
        '{8'd0, 1'b1, 1'b1, '{16'd0, 16'd0, 1'b0, 1'b0, 1'b1}},
        // single 255: component equals sum, saturates
        '{8'd255, 1'b1, 1'b1, '{16'hffff, 16'd0, 1'b0, 1'b0, 1'b1}},
        // pair 255, 0
        '{8'd255, 1'b0, 1'b0, '{16'd0, 16'd0, 1'b0, 1'b0, 1'b0}},
        '{8'd0, 1'b1, 1'b1, '{16'hffff, 16'd0, 1'b1, 1'b0, 1'b1}},
        // equal pair: sqrt(1/2)
        '{8'd1, 1'b0, 1'b0, '{16'd0, 16'd0, 1'b0, 1'b0, 1'b0}},
        '{8'd1, 1'b1, 1'b0, '{16'd0, 16'd0, 1'b0, 1'b0, 1'b0}},
        // three-word row, odd length
        '{8'd170, 1'b0, 1'b0, '{16'd0, 16'd0, 1'b0, 1'b0, 1'b0}},
        '{8'd85, 1'b0, 1'b0, '{16'd0, 16'd0, 1'b0, 1'b0, 1'b0}},
        '{8'd1, 1'b1, 1'b0, '{16'd0, 16'd0, 1'b0, 1'b0, 1'b0}},
        // all-zero pair
        '{8'd0, 1'b0, 1'b0, '{16'd0, 16'd0, 1'b0, 1'b0, 1'b0}},
        '{8'd0, 1'b1, 1'b1, '{16'd0, 16'd0, 1'b1, 1'b0, 1'b1}}
    };

    // stimulus
    initial begin
        repeat (4) @(posedge aclk);
        aresetn <= 1;
        @(posedge aclk);
        foreach (table_rows[i]) begin
            if (table_rows[i].last) begin
                typed_has.push_back(table_rows[i].has_pair);
                typed_pairs.push_back(table_rows[i].pair);
            end
            send_word(table_rows[i].value, table_rows[i].last);
            idle_gap();
        end
        // full row of 255 covers the max sum
        for (int i = 0; i < ROWS; i++) send_word(8'hff, i == ROWS - 1);
        // overflow row whose last word lands when the store is full
        for (int i = 0; i < ROWS + 2; i++) send_word(i[7:0], i == ROWS + 1);
        wait_drained();
        // long output stall while the sender keeps offering words
        hold_off = 1;
        for (int r = 0; r < 3; r++) random_row();
        while (words_in < 450) begin
            random_row();
            if (words_in > 200 && hold_off) hold_off = 0;
        end
        hold_off = 0;
        stim_done = 1;
        wait_drained();
    end

    // receiver: random stalls plus one long counted hold-off
    initial begin
        int stall_left;
        int held;
        stall_left = 0;
        held = 0;
        @(posedge aresetn);
        forever begin
            @(posedge aclk);
            if (hold_off && held < 4000) begin
                held++;
                m_tready <= 0;
            end else if (stall_left > 0) begin
                stall_left--;
                m_tready <= 0;
            end else begin
                m_tready <= 1;
                if ($urandom_range(0, 7) == 0)
                    stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 60)
                                                               : $urandom_range(1, 3);
            end
        end
    end

    // checker
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            pair_t got;
            pair_t want;
            pair_t typed;
            bit    has;
            got = {m_tdata[15:0], m_tdata[31:16], m_tuser[0], m_tuser[1], m_tlast};
            pairs_out++;
            if (got.last_pair) rows_done++;
            if (pending_pairs.size() == 0) begin
                $error("unexpected pair %h", got);
                errors++;
            end else begin
                want = pending_pairs.pop_front();
                // predictor's first pair of a directed row against its typed-in value
                if (row_start && typed_has.size() != 0) begin
                    has = typed_has.pop_front();
                    typed = typed_pairs.pop_front();
                    if (has && typed != want) begin
                        $error("typed pair %h differs from predictor %h", typed, want);
                        errors++;
                    end
                end
                if (got.root_even !== want.root_even) begin
                    $error("root_even exp %h got %h", want.root_even, got.root_even);
                    errors++;
                end
                if (got.root_odd !== want.root_odd) begin
                    $error("root_odd exp %h got %h", want.root_odd, got.root_odd);
                    errors++;
                end
                if (got.odd_valid !== want.odd_valid) begin
                    $error("odd_valid exp %b got %b", want.odd_valid, got.odd_valid);
                    errors++;
                end
                if (got.row_overflow !== want.row_overflow) begin
                    $error("row_overflow exp %b got %b", want.row_overflow, got.row_overflow);
                    errors++;
                end
                if (got.last_pair !== want.last_pair) begin
                    $error("last_pair exp %b got %b", want.last_pair, got.last_pair);
                    errors++;
                end
            end
            row_start = got.last_pair;
        end
    end

    // end of run and timeout
    initial begin
        @(posedge aresetn);
        while (!(stim_done && pending_pairs.size() == 0) && cycles < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycles++;
        end
        if (cycles >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("SCOREBOARD MISMATCH");
            $finish;
        end else begin
            repeat (200) @(posedge aclk);
            if (pending_pairs.size() != 0) errors++;
            $display("%0d words in, %0d rows and %0d pairs checked", words_in, rows_done,
                     pairs_out);
            if (errors == 0) begin
                $display("SCOREBOARD CLEAN");
            end else begin
                $display("SCOREBOARD MISMATCH");
            end
            $finish;
        end
    end
endmodule
